[rtl/drop_pair_collision_resolve_top_assert.svh]
`ifndef DROP_PAIR_COLLISION_RESOLVE_TOP_ASSERT_SVH
`define DROP_PAIR_COLLISION_RESOLVE_TOP_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define DPCR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds, consequent holds after the delay given by dly
`define DPCR_ASSERT_DELAY(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

[rtl/dpcr_pkg.sv]
`default_nettype none
package dpcr_pkg;

   localparam int POS_W     = 24;
   localparam int TOTAL_W   = 17;
   localparam int DIV_STEPS = 28;
   localparam int MAG_W     = TOTAL_W + DIV_STEPS;
   localparam int LATENCY   = DIV_STEPS + 5;

   localparam logic [15:0] TIME_STEP_RESET = 16'd68;
   localparam logic [16:0] REACH_EXTRA     = 17'd768;
   localparam logic [0:0]  REG_TIME_STEP   = 1'b0;

   typedef struct packed {
      logic signed [23:0] first_x;
      logic signed [23:0] first_y;
      logic signed [23:0] second_x;
      logic signed [23:0] second_y;
      logic        [15:0] first_radius;
      logic        [15:0] first_mass;
      logic        [15:0] second_mass;
      logic signed [23:0] first_vel_y;
      logic signed [23:0] second_vel_y;
   } dpcr_req_type;

   typedef struct packed {
      logic               hit;
      logic signed [23:0] new_first_x;
      logic signed [23:0] new_first_y;
      logic signed [23:0] new_second_x;
      logic signed [23:0] new_second_y;
      logic signed [23:0] new_first_vel_y;
      logic signed [23:0] new_second_vel_y;
   } dpcr_rsp_type;

   // item after the geometry stages, waiting on the divider
   typedef struct packed {
      logic                 hit;
      logic                 sel_second;
      logic                 zero_mass;
      logic                 neg;
      logic [TOTAL_W-1:0]   total;
      logic [MAG_W-1:0]     mag;
      logic signed [23:0]   x1;
      logic signed [23:0]   y1;
      logic signed [23:0]   x2;
      logic signed [23:0]   y2;
      logic signed [23:0]   v1;
      logic signed [23:0]   v2;
   } dpcr_mid_type;

   function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
      logic signed [24:0] hi;
      logic signed [24:0] lo;
      hi = 25'sd8388607;
      lo = -25'sd8388608;
      if (v > hi) begin
         sat24 = 24'sh7fffff;
      end else if (v < lo) begin
         sat24 = 24'sh800000;
      end else begin
         sat24 = v[23:0];
      end
   endfunction

endpackage
`default_nettype wire

[rtl/dpcr_front.sv]
`default_nettype none
module dpcr_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_vld,
   input  dpcr_pkg::dpcr_req_type in_req,
   input  wire [15:0]            dt,
   output logic                  out_vld,
   output dpcr_pkg::dpcr_mid_type out_mid
);
   import dpcr_pkg::*;

   // stage a: differences, reach, momenta
   logic               a_vld_ff;
   dpcr_req_type       a_req_ff;
   logic signed [24:0] a_dx_ff, a_dy_ff;
   logic [16:0]        a_r_ff;
   logic signed [40:0] a_pa_ff, a_pb_ff;
   logic [TOTAL_W-1:0] a_total_ff;
   // stage b: squares, momentum sum
   logic               b_vld_ff;
   dpcr_req_type       b_req_ff;
   logic [48:0]        b_dx2_ff, b_dy2_ff;
   logic [33:0]        b_r2_ff;
   logic [15:0]        b_h_ff;
   logic signed [41:0] b_sum_ff;
   logic [TOTAL_W-1:0] b_total_ff;
   // stage c: compare, scaled numerator
   logic               c_vld_ff;
   dpcr_req_type       c_req_ff;
   logic               c_hit_ff;
   logic [15:0]        c_h_ff;
   logic signed [58:0] c_num_ff;
   logic [TOTAL_W-1:0] c_total_ff;
   // stage d
   logic               d_vld_ff;
   dpcr_mid_type       d_mid_ff;
   dpcr_mid_type       d_mid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_vld;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
      a_req_ff   <= in_req;
      a_dx_ff    <= 25'(in_req.second_x) - 25'(in_req.first_x);
      a_dy_ff    <= 25'(in_req.second_y) - 25'(in_req.first_y);
      a_r_ff     <= {1'b0, in_req.first_radius} + REACH_EXTRA;
      a_pa_ff    <= 41'($signed({1'b0, in_req.first_mass}) * in_req.first_vel_y);
      a_pb_ff    <= 41'($signed({1'b0, in_req.second_mass}) * in_req.second_vel_y);
      a_total_ff <= {1'b0, in_req.first_mass} + {1'b0, in_req.second_mass};

      b_req_ff   <= a_req_ff;
      b_dx2_ff   <= 49'(a_dx_ff * a_dx_ff);
      b_dy2_ff   <= 49'(a_dy_ff * a_dy_ff);
      b_r2_ff    <= a_r_ff * a_r_ff;
      b_h_ff     <= a_r_ff[16:1];
      b_sum_ff   <= 42'(a_pa_ff) + 42'(a_pb_ff);
      b_total_ff <= a_total_ff;

      c_req_ff   <= b_req_ff;
      c_hit_ff   <= ({1'b0, b_dx2_ff} + {1'b0, b_dy2_ff}) < {16'b0, b_r2_ff};
      c_h_ff     <= b_h_ff;
      c_num_ff   <= 59'(b_sum_ff * $signed({1'b0, dt}));
      c_total_ff <= b_total_ff;

      d_mid_ff <= d_mid_in;
   end

   always_comb begin
      logic signed [24:0] ax, ay, bx, by, hs;
      logic [58:0]        absn;
      ax = 25'(c_req_ff.first_x);
      ay = 25'(c_req_ff.first_y);
      bx = 25'(c_req_ff.second_x);
      by = 25'(c_req_ff.second_y);
      hs = $signed({9'b0, c_h_ff});
      absn = c_num_ff[58] ? 59'(-c_num_ff) : 59'(c_num_ff);
      d_mid_in.hit        = c_hit_ff;
      d_mid_in.sel_second = ay > by;
      d_mid_in.zero_mass  = (c_total_ff == '0);
      d_mid_in.neg        = c_num_ff[58];
      d_mid_in.total      = c_total_ff;
      d_mid_in.mag        = absn[MAG_W+11:12];
      d_mid_in.x1         = c_req_ff.first_x;
      d_mid_in.y1         = c_req_ff.first_y;
      d_mid_in.x2         = c_req_ff.second_x;
      d_mid_in.y2         = c_req_ff.second_y;
      d_mid_in.v1         = c_req_ff.first_vel_y;
      d_mid_in.v2         = c_req_ff.second_vel_y;
      if (c_hit_ff) begin
         if (ax > bx) begin
            d_mid_in.x1 = sat24(ax + hs);
            d_mid_in.x2 = sat24(bx - hs);
         end else begin
            d_mid_in.x1 = sat24(ax - hs);
            d_mid_in.x2 = sat24(bx + hs);
         end
         if (ay > by) begin
            d_mid_in.y2 = sat24(ay - hs);
         end else begin
            d_mid_in.y1 = sat24(by - hs);
         end
      end
   end

   assign out_vld = d_vld_ff;
   assign out_mid = d_mid_ff;
endmodule
`default_nettype wire

[rtl/dpcr_div.sv]
`default_nettype none
module dpcr_div (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_vld,
   input  dpcr_pkg::dpcr_mid_type in_mid,
   output logic                   out_vld,
   output dpcr_pkg::dpcr_mid_type out_mid,
   output logic [dpcr_pkg::DIV_STEPS-1:0] out_quo
);
   import dpcr_pkg::*;

   // one restoring step per stage, quotient bits shift in at the bottom
   logic                 vld_ff [DIV_STEPS];
   dpcr_mid_type         mid_ff [DIV_STEPS];
   logic [TOTAL_W-1:0]   rem_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] low_ff [DIV_STEPS];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      logic                 src_vld;
      dpcr_mid_type         src_mid;
      logic [TOTAL_W-1:0]   src_rem;
      logic [DIV_STEPS-1:0] src_low;
      logic [TOTAL_W:0]     trial;
      logic                 fits;

      if (i == 0) begin : g_first
         assign src_vld = in_vld;
         assign src_mid = in_mid;
         assign src_rem = in_mid.mag[MAG_W-1:DIV_STEPS];
         assign src_low = in_mid.mag[DIV_STEPS-1:0];
      end else begin : g_next
         assign src_vld = vld_ff[i-1];
         assign src_mid = mid_ff[i-1];
         assign src_rem = rem_ff[i-1];
         assign src_low = low_ff[i-1];
      end

      assign trial = {src_rem, src_low[DIV_STEPS-1]};
      assign fits  = trial >= {1'b0, src_mid.total};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= src_vld;
         end
         mid_ff[i] <= src_mid;
         rem_ff[i] <= fits ? TOTAL_W'(trial - {1'b0, src_mid.total})
                           : TOTAL_W'(trial);
         low_ff[i] <= {src_low[DIV_STEPS-2:0], fits};
      end
   end

   assign out_vld = vld_ff[DIV_STEPS-1];
   assign out_mid = mid_ff[DIV_STEPS-1];
   assign out_quo = low_ff[DIV_STEPS-1];
endmodule
`default_nettype wire

[rtl/drop_pair_collision_resolve_top.sv]
`default_nettype none
// a result strobes on rsp_valid after front stages a to d, the 28-stage divider and the output register
// throughput: one item per cycle, busy stays low and nothing stalls the pipeline
// reset: synchronous active high; clears all in-flight items, time_step back to 68
// the receiver cannot stall, every result is shown for exactly one cycle
`include "drop_pair_collision_resolve_top_assert.svh"
module drop_pair_collision_resolve_top (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  dpcr_pkg::dpcr_req_type req_data,
   output logic                   rsp_valid,
   output dpcr_pkg::dpcr_rsp_type rsp_data,
   input  wire                    psel,
   input  wire                    penable,
   input  wire                    pwrite,
   input  wire  [2:0]             paddr,
   input  wire  [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import dpcr_pkg::*;

   // config register
   logic [15:0] time_step_ff;
   logic        csr_wr;

   // front pipeline out
   logic         mid_vld;
   dpcr_mid_type mid;
   // divider out
   logic                 div_vld;
   dpcr_mid_type         div_mid;
   logic [DIV_STEPS-1:0] div_quo;

   // output register
   logic         rsp_valid_ff;
   dpcr_rsp_type rsp_data_ff;
   dpcr_rsp_type rsp_data_in;

   // no backpressure anywhere, an item can enter every cycle
   assign busy   = 1'b0;
   assign pready = 1'b1;

   assign csr_wr = psel && penable && pwrite && (paddr[2] == REG_TIME_STEP);

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
      end else if (csr_wr) begin
         time_step_ff <= pwdata[15:0];
      end
   end

   assign prdata = (paddr[2] == REG_TIME_STEP) ? {16'b0, time_step_ff} : 32'b0;

   // geometry, overlap test, momentum numerator
   dpcr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (start && !busy),
      .in_req  (req_data),
      .dt      (time_step_ff),
      .out_vld (mid_vld),
      .out_mid (mid)
   );

   // |numerator| / 4096 / total mass, one quotient bit per stage
   dpcr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (mid_vld),
      .in_mid  (mid),
      .out_vld (div_vld),
      .out_mid (div_mid),
      .out_quo (div_quo)
   );

   // sign, saturate, and for a hit route the merged velocity to the lower drop
   always_comb begin
      logic signed [23:0] vel;
      logic [DIV_STEPS-1:0] lim_pos;
      logic [DIV_STEPS-1:0] lim_neg;
      lim_pos = DIV_STEPS'(24'h7fffff);
      lim_neg = DIV_STEPS'(25'h0800000);
      if (div_mid.zero_mass) begin
         vel = '0;
      end else if (div_mid.neg) begin
         if (div_quo >= lim_neg) begin
            vel = 24'sh800000;
         end else begin
            vel = 24'(-$signed({1'b0, div_quo}));
         end
      end else if (div_quo > lim_pos) begin
         vel = 24'sh7fffff;
      end else begin
         vel = div_quo[23:0];
      end
      rsp_data_in.hit              = div_mid.hit;
      rsp_data_in.new_first_x      = div_mid.x1;
      rsp_data_in.new_first_y      = div_mid.y1;
      rsp_data_in.new_second_x     = div_mid.x2;
      rsp_data_in.new_second_y     = div_mid.y2;
      rsp_data_in.new_first_vel_y  = div_mid.v1;
      rsp_data_in.new_second_vel_y = div_mid.v2;
      if (div_mid.hit) begin
         if (div_mid.sel_second) begin
            rsp_data_in.new_second_vel_y = vel;
         end else begin
            rsp_data_in.new_first_vel_y = vel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_vld;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // every accepted item comes out on rsp_valid after passing the whole pipeline
   `DPCR_ASSERT_DELAY(a_latency, clock, reset, start && !busy, 33, rsp_valid, "item lost in pipe")
   // a pair that misses passes its positions through untouched
   `DPCR_ASSERT_IMPL(a_miss_x, clock, reset, rsp_valid && !rsp_data.hit, rsp_data.new_first_x == $past(req_data.first_x, 33), "miss changed first x")
   `DPCR_ASSERT_IMPL(a_miss_v, clock, reset, rsp_valid && !rsp_data.hit, rsp_data.new_second_vel_y == $past(req_data.second_vel_y, 33), "miss changed velocity")
endmodule
`default_nettype wire
